@@ hdl/fic_pkg.sv @@
package fic_pkg;

  // fixed widths of the result fields
  localparam int COEF_W = 38;
  localparam int POS_W  = 6;

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } fic_state_e;

  // strobes broadcast from the controller to every cell
  typedef struct packed {
    logic step;    // advance the chain by one coefficient
    logic first;   // first step of a run, ignore stale partial sums
    logic load_a;  // write an A element into the addressed cell
    logic load_b;  // write a B element into the addressed cell
  } cell_ctl_t;

endpackage

@@ hdl/fft_integer_convolution.sv @@
// channel | direction | handshake                   | payload
// --------+-----------+-----------------------------+-----------------------------------------
// in      | sink      | in_valid_i / in_stall_o     | req_type_i, sample_i, end_of_sequence_i
// out     | source    | out_valid_o / out_stall_i   | coefficient_o, position_o, final_item_o,
//         |           |                             | overflow_o
//
// loading takes one input beat per cycle; the beat that ends B starts the run on the next cycle
// a run of len = len_a + len_b - 1 coefficients makes one cell chain step per coefficient
// in_stall_o stays high for the whole run; out_stall_i freezes the chain in place
// loading of the next run may go on while the last coefficient still waits at the output
// reset clears only control state; no clearing pass is needed
module fft_integer_convolution #(
  parameter int FFT_POINTS  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic                              end_of_sequence_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fic_pkg::COEF_W-1:0] coefficient_o,
  output logic [fic_pkg::POS_W-1:0]         position_o,
  output logic                              final_item_o,
  output logic                              overflow_o
);
  import fic_pkg::*;

  // count width holds 0 .. FFT_POINTS
  localparam int CW = $clog2(FFT_POINTS + 1);
  // exact sum of FFT_POINTS products of two samples
  localparam int AW = 2 * SAMPLE_BITS + $clog2(FFT_POINTS);

  cell_ctl_t                    cell_ctl;
  logic [CW-1:0]                wr_idx;
  logic [CW-1:0]                a_cnt;
  logic                         x_en;
  logic signed [SAMPLE_BITS-1:0] x_bcast;

  // b elements shift towards cell 0, partial sums travel the same way
  logic signed [SAMPLE_BITS-1:0] b_chain [FFT_POINTS+1];
  logic signed [AW-1:0]          s_chain [FFT_POINTS+1];

  fic_ctrl #(
    .FFT_POINTS (FFT_POINTS),
    .CW         (CW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .position_o        (position_o),
    .final_item_o      (final_item_o),
    .overflow_o        (overflow_o),
    .cell_ctl_o        (cell_ctl),
    .wr_idx_o          (wr_idx),
    .a_cnt_o           (a_cnt),
    .x_en_o            (x_en)
  );

  // cell i holds a[i] fixed; the b element leaving cell 0 is broadcast to all
  // cells, past the end of B the chain is fed with zero
  assign x_bcast = x_en ? b_chain[0] : '0;

  assign b_chain[FFT_POINTS] = '0;
  assign s_chain[FFT_POINTS] = '0;

  for (genvar i = 0; i < FFT_POINTS; i++) begin : g_cell
    fic_cell #(
      .SW  (SAMPLE_BITS),
      .AW  (AW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (cell_ctl),
      .wr_idx_i  (wr_idx),
      .wr_data_i (sample_i),
      .a_cnt_i   (a_cnt),
      .x_i       (x_bcast),
      .b_next_i  (b_chain[i+1]),
      .s_next_i  (s_chain[i+1]),
      .b_o       (b_chain[i]),
      .s_o       (s_chain[i])
    );
  end

  // the sum register of cell 0 doubles as the result register: it only moves
  // on a step, and a step needs the previous coefficient to be taken
  assign coefficient_o = COEF_W'(s_chain[0]);

endmodule

@@ hdl/fic_cell.sv @@
module fic_cell #(
  parameter int SW  = 16,
  parameter int AW  = 38,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  fic_pkg::cell_ctl_t      ctl_i,
  input  logic [CW-1:0]           wr_idx_i,
  input  logic signed [SW-1:0]    wr_data_i,
  input  logic [CW-1:0]           a_cnt_i,
  input  logic signed [SW-1:0]    x_i,
  input  logic signed [SW-1:0]    b_next_i,
  input  logic signed [AW-1:0]    s_next_i,
  output logic signed [SW-1:0]    b_o,
  output logic signed [AW-1:0]    s_o
);
  import fic_pkg::*;

  localparam int PW = 2 * SW;
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [SW-1:0] a_q;
  logic signed [SW-1:0] b_q;
  logic signed [AW-1:0] s_q;
  logic signed [AW-1:0] s_d;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] prod_ext;
  logic                 a_used;
  logic                 hit;

  assign hit    = (wr_idx_i == MY_IDX);
  // coefficient slots past the end of A hold stale data, treat them as zero
  assign a_used = (MY_IDX < a_cnt_i);

  always_comb begin
    // signed product, kept apart from the zero arm so both factors sign-extend
    if (a_used) begin
      prod = a_q * x_i;
    end else begin
      prod = '0;
    end
    prod_ext = AW'(prod);
    s_d      = ctl_i.first ? prod_ext : (prod_ext + s_next_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_a && hit) begin
      a_q <= wr_data_i;
    end
    if (ctl_i.load_b && hit) begin
      b_q <= wr_data_i;
    end else if (ctl_i.step) begin
      b_q <= b_next_i;
    end
    if (ctl_i.step) begin
      s_q <= s_d;
    end
  end

  assign b_o = b_q;
  assign s_o = s_q;

endmodule

@@ hdl/fic_ctrl.sv @@
module fic_ctrl #(
  parameter int FFT_POINTS = 64,
  parameter int CW         = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic                        end_of_sequence_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fic_pkg::POS_W-1:0]   position_o,
  output logic                        final_item_o,
  output logic                        overflow_o,
  output fic_pkg::cell_ctl_t          cell_ctl_o,
  output logic [CW-1:0]               wr_idx_o,
  output logic [CW-1:0]               a_cnt_o,
  output logic                        x_en_o
);
  import fic_pkg::*;

  localparam logic [CW-1:0] NPTS = CW'(FFT_POINTS);

  fic_state_e        state_q, state_d;
  logic [CW-1:0]     count_a_q, count_a_d;
  logic [CW-1:0]     count_b_q, count_b_d;
  logic              dropped_q, dropped_d;
  logic [CW-1:0]     len_q, len_d;
  logic [CW-1:0]     t_q, t_d;
  logic              ovf_run_q, ovf_run_d;
  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              final_q, final_d;
  logic              ovf_q, ovf_d;

  logic              accept;
  logic              fit;
  logic              load_a;
  logic              load_b;
  logic              start;
  logic              empty;
  logic              step;
  logic              last_step;
  logic [CW-1:0]     own;
  logic [CW:0]       total;
  logic [CW-1:0]     cnt_a_new;
  logic [CW-1:0]     cnt_b_new;
  logic [CW-1:0]     t_inc;

  // ---- admission of input beats ----
  always_comb begin
    accept    = in_valid_i && !in_stall_o;
    own       = req_type_i ? count_b_q : count_a_q;
    total     = {1'b0, count_a_q} + {1'b0, count_b_q};
    fit       = (own < NPTS) && (total <= {1'b0, NPTS});
    load_a    = accept && fit && !req_type_i;
    load_b    = accept && fit && req_type_i;
    start     = accept && req_type_i && end_of_sequence_i;
    cnt_a_new = load_a ? (count_a_q + CW'(1)) : count_a_q;
    cnt_b_new = load_b ? (count_b_q + CW'(1)) : count_b_q;
    empty     = (cnt_a_new == '0) || (cnt_b_new == '0);
    t_inc     = t_q + CW'(1);
    last_step = (t_inc == len_q);
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (start && !empty) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step && last_step) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // ---- state outputs ----
  always_comb begin
    in_stall_o = 1'b0;
    step       = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
      end
      ST_RUN: begin
        in_stall_o = 1'b1;
        step       = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // ---- counters and result fields ----
  always_comb begin
    count_a_d   = cnt_a_new;
    count_b_d   = cnt_b_new;
    dropped_d   = dropped_q || (accept && !fit);
    len_d       = len_q;
    t_d         = t_q;
    ovf_run_d   = ovf_run_q;
    pos_d       = pos_q;
    final_d     = final_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (start && !empty) begin
      len_d     = CW'({1'b0, cnt_a_new} + {1'b0, cnt_b_new} - {{CW{1'b0}}, 1'b1});
      t_d       = '0;
      ovf_run_d = dropped_d;
    end

    if (step) begin
      t_d         = t_inc;
      pos_d       = POS_W'(t_q);
      final_d     = last_step;
      ovf_d       = ovf_run_q;
      out_valid_d = 1'b1;
    end

    // run over or nothing to convolve: back to an empty run
    if ((start && empty) || (step && last_step)) begin
      count_a_d = '0;
      count_b_d = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_a_q   <= '0;
      count_b_q   <= '0;
      dropped_q   <= 1'b0;
      len_q       <= '0;
      t_q         <= '0;
      ovf_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      final_q     <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_a_q   <= count_a_d;
      count_b_q   <= count_b_d;
      dropped_q   <= dropped_d;
      len_q       <= len_d;
      t_q         <= t_d;
      ovf_run_q   <= ovf_run_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      final_q     <= final_d;
      ovf_q       <= ovf_d;
    end
  end

  always_comb begin
    cell_ctl_o.step   = step;
    cell_ctl_o.first  = (t_q == '0);
    cell_ctl_o.load_a = load_a;
    cell_ctl_o.load_b = load_b;
  end

  assign wr_idx_o     = req_type_i ? count_b_q : count_a_q;
  assign a_cnt_o      = count_a_q;
  assign x_en_o       = (t_q < count_b_q);
  assign out_valid_o  = out_valid_q;
  assign position_o   = pos_q;
  assign final_item_o = final_q;
  assign overflow_o   = ovf_q;

  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (t_q < len_q))
    else $error("step counter beyond result length");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_step) |=> (state_q == ST_LOAD && count_a_q == '0 && count_b_q == '0))
    else $error("run did not return to an empty load phase");

  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_a || load_b) |-> (state_q == ST_LOAD))
    else $error("element written while the chain runs");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_a_q} + {1'b0, count_b_q}) <= ({1'b0, NPTS} + {{CW{1'b0}}, 1'b1}))
    else $error("loaded elements exceed capacity");

  a_result_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (out_valid_q && pos_q == POS_W'($past(t_q))))
    else $error("result position does not follow the step counter");

endmodule

@@ dv/tb_fft_integer_convolution.sv @@
module tb_fft_integer_convolution;
  import fic_pkg::*;

  localparam int POINTS = 64;
  localparam int SBITS = 16;

  // element kinds on req_type_i
  localparam logic SEQ_A = 1'b0;
  localparam logic SEQ_B = 1'b1;

  localparam logic signed [SBITS-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SBITS-1:0] S_MAX = 16'sh7fff;

  localparam int RANDOM_BEATS = 50;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int LIMIT_CYCLES = 500000;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [POS_W-1:0]         pos;
    logic                     is_final;
    logic                     ovf;
  } coef_beat_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     req_type_i = SEQ_A;
  logic signed [SBITS-1:0]  sample_i = '0;
  logic                     end_of_sequence_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [COEF_W-1:0] coefficient_o;
  logic [POS_W-1:0]         position_o;
  logic                     final_item_o;
  logic                     overflow_o;

  // own copy of the block state: collected elements, counts, drop flag
  logic signed [SBITS-1:0] held_a [POINTS];
  logic signed [SBITS-1:0] held_b [POINTS];
  int n_a = 0;
  int n_b = 0;
  bit run_dropped = 1'b0;

  // coefficients still owed by the block, oldest first
  coef_beat_t pending_coefs [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  beats_sent = 0;
  bit  idle_in = 1'b1;
  bit  idle_out = 1'b1;
  int  hold_requests = 0;
  int  hold_served = 0;

  fft_integer_convolution u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .coefficient_o     (coefficient_o),
    .position_o        (position_o),
    .final_item_o      (final_item_o),
    .overflow_o        (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  // watchdog: a correct run stays far below this
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("fft_integer_convolution verification failed");
      $finish;
    end
  end

  // most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // extremes often, otherwise any 16-bit pattern
  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return -16'sd1;
      default: return SBITS'($urandom);
    endcase
  endfunction

  // sequence lengths: mostly short, now and then long
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 6);
    return $urandom_range(7, 32);
  endfunction

  // accepted beat -> update the collected sequences; the end of B yields the
  // direct-sum convolution, one expected beat per coefficient
  task automatic absorb_beat(input logic kind, input logic signed [SBITS-1:0] val,
                             input logic eos);
    int         own;
    int         len;
    int         k;
    int         i;
    longint     acc;
    coef_beat_t c;
    own = (kind == SEQ_B) ? n_b : n_a;
    // capacity: own store not full and the result fits in the transform
    if (own < POINTS && n_a + n_b <= POINTS) begin
      if (kind == SEQ_B) begin
        held_b[n_b] = val;
        n_b++;
      end else begin
        held_a[n_a] = val;
        n_a++;
      end
    end else begin
      run_dropped = 1'b1;
    end
    // only the end of B starts a run, even when that element was dropped
    if (kind == SEQ_B && eos) begin
      if (n_a != 0 && n_b != 0) begin
        len = n_a + n_b - 1;
        for (k = 0; k < len; k++) begin
          acc = 0;
          for (i = 0; i < n_a; i++) begin
            if (k >= i && k - i < n_b) acc += longint'(held_a[i]) * longint'(held_b[k - i]);
          end
          c.coef     = acc[COEF_W-1:0];
          c.pos      = k[POS_W-1:0];
          c.is_final = (k + 1 == len);
          c.ovf      = run_dropped;
          pending_coefs.push_back(c);
        end
      end
      // empty run or finished run: everything back to zero
      n_a = 0;
      n_b = 0;
      run_dropped = 1'b0;
    end
  endtask

  // offers one beat after an optional gap and holds it until taken
  task automatic send_beat(input logic kind, input logic signed [SBITS-1:0] val,
                           input logic eos);
    int gap;
    gap = idle_in ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    req_type_i        <= kind;
    sample_i          <= val;
    end_of_sequence_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    absorb_beat(kind, val, eos);
    beats_sent++;
  endtask

  task automatic send_repeat(input logic kind, input int count,
                             input logic signed [SBITS-1:0] val);
    repeat (count) send_beat(kind, val, 1'b0);
  endtask

  // one run: la elements of A and lb of B, the last B carrying the end mark;
  // mixed interleaves the two, noisy puts stray end marks on A elements
  task automatic send_run(input int la, input int lb, input bit mixed, input bit noisy);
    int ra;
    int rb;
    bit pick_a;
    ra = la;
    rb = lb - 1;
    while (ra > 0 || rb > 0) begin
      if (!mixed) pick_a = (ra > 0);
      else pick_a = (rb == 0) || (ra > 0 && $urandom_range(0, ra + rb - 1) < ra);
      if (pick_a) begin
        send_beat(SEQ_A, pick_sample(), noisy && ($urandom_range(0, 3) == 0));
        ra--;
      end else begin
        send_beat(SEQ_B, pick_sample(), 1'b0);
        rb--;
      end
    end
    send_beat(SEQ_B, pick_sample(), 1'b1);
  endtask

  // sender goes quiet until every owed coefficient has arrived
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_coefs.size() != 0);
  endtask

  // extremes of the samples, end mark on A, interleaving, zero
  task automatic test_directed_extremes();
    send_beat(SEQ_A, S_MIN, 1'b0);
    send_beat(SEQ_B, S_MIN, 1'b1);
    send_beat(SEQ_A, S_MAX, 1'b0);
    send_beat(SEQ_B, S_MIN, 1'b1);
    send_beat(SEQ_A, S_MAX, 1'b0);
    send_beat(SEQ_A, S_MIN, 1'b0);
    send_beat(SEQ_A, -16'sd1, 1'b0);
    send_beat(SEQ_B, S_MAX, 1'b0);
    send_beat(SEQ_B, S_MIN, 1'b0);
    send_beat(SEQ_B, 16'sd1, 1'b1);
    // an end mark on A changes nothing
    send_beat(SEQ_A, 16'sd5, 1'b1);
    send_beat(SEQ_A, -16'sd7, 1'b1);
    send_beat(SEQ_B, 16'sd3, 1'b1);
    // B elements ahead of and between A elements
    send_beat(SEQ_B, 16'sd2, 1'b0);
    send_beat(SEQ_A, -16'sd3, 1'b0);
    send_beat(SEQ_B, S_MAX, 1'b0);
    send_beat(SEQ_A, S_MIN, 1'b0);
    send_beat(SEQ_B, 16'sd0, 1'b1);
    send_beat(SEQ_A, 16'sd0, 1'b0);
    send_beat(SEQ_B, 16'sd0, 1'b1);
    wait_results_drained();
  endtask

  // runs with no A give nothing and clear what B had collected; a run of one A and one B ends it
  task automatic test_empty_sequence();
    send_beat(SEQ_B, S_MAX, 1'b1);
    send_beat(SEQ_B, 16'sd4, 1'b0);
    send_beat(SEQ_B, -16'sd9, 1'b1);
    send_beat(SEQ_A, 16'sd2, 1'b0);
    send_beat(SEQ_B, 16'sd3, 1'b1);
    wait_results_drained();
  endtask

  // full-length result at peak magnitude, dropped elements and the overflow flag
  task automatic test_capacity();
    send_repeat(SEQ_A, 32, S_MIN);
    send_repeat(SEQ_B, 32, S_MIN);
    send_beat(SEQ_B, S_MIN, 1'b1);
    // B overfull: the dropped end element still starts the run
    send_beat(SEQ_A, -16'sd1, 1'b0);
    send_repeat(SEQ_B, POINTS + 2, S_MAX);
    send_beat(SEQ_B, 16'sd9, 1'b1);
    send_run(36, 30, 1'b1, 1'b0);
    send_run(2, 2, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // mostly well-formed runs with random content, the rest noise and broken runs
  task automatic test_random_runs();
    int start;
    int r;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      // stretches without any idling on either side
      idle_in  = ($urandom_range(0, 4) != 0);
      idle_out = ($urandom_range(0, 4) != 0);
      if (r < 70) begin
        send_run(pick_len(), pick_len(), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 3) == 0);
      end else if (r < 82) begin
        send_run(pick_len(), pick_len(), 1'b1, 1'b1);
      end else if (r < 90) begin
        send_run(0, pick_len(), 1'b0, 1'b0);
      end else if (r < 95) begin
        send_run($urandom_range(30, 66), $urandom_range(1, 20), 1'b1, 1'b0);
      end else begin
        // stray A element with an end mark, absorbed into the next run
        send_beat(SEQ_A, pick_sample(), 1'b1);
      end
    end
    idle_in  = 1'b1;
    idle_out = 1'b1;
    wait_results_drained();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_requests++;
    send_run(5, 7, 1'b0, 1'b0);
    send_run(8, 3, 1'b1, 1'b0);
    send_run(4, 4, 1'b0, 1'b0);
    send_run(6, 6, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // sender waits for every result before the next run
  task automatic test_drain_pause();
    send_run(3, 3, 1'b0, 1'b0);
    wait_results_drained();
    send_run(7, 2, 1'b1, 1'b0);
    wait_results_drained();
  endtask

  // receiver side: random stall lengths, and the long hold when asked
  initial begin : stall_driver
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_served != hold_requests) begin
        hold_served++;
        n = LONG_HOLD;
      end else begin
        n = idle_out ? pick_gap() : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  // every accepted result beat against the oldest owed coefficient
  always @(posedge clk_i) begin
    coef_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_coefs.size() == 0) begin
        $error("result beat with nothing owed: position %0d coefficient %0d",
               position_o, coefficient_o);
        fail_count++;
      end else begin
        want = pending_coefs.pop_front();
        if (coefficient_o !== want.coef) begin
          $error("coefficient: expected %0d, got %0d", want.coef, coefficient_o);
          fail_count++;
        end
        if (position_o !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, position_o);
          fail_count++;
        end
        if (final_item_o !== want.is_final) begin
          $error("final_item: expected %0b, got %0b", want.is_final, final_item_o);
          fail_count++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, overflow_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_empty_sequence();
    test_capacity();
    test_random_runs();
    test_backpressure();
    test_drain_pause();
    wait_results_drained();
    // room for any late or spurious beat to show up
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("fft_integer_convolution verification clean");
    end else begin
      $display("fft_integer_convolution verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fic_pkg.sv
hdl/fic_cell.sv
hdl/fic_ctrl.sv
hdl/fft_integer_convolution.sv
dv/tb_fft_integer_convolution.sv
